>>> rtl/core/srrc_pkg.sv
// Shared constants, register codes and pipeline word type for the symbol rate calculator.
package srrc_pkg;

    // Crystal frequency in Hz; RATE_MAX, each threshold and divisor derive from it.
    localparam longint unsigned XTAL_HZ = 64'd69600000;

    localparam int RATE_W    = 26;
    localparam int REQ_W     = 32;
    localparam int NDEC_W    = 2;
    localparam int BYTE_W    = 8;
    localparam int DBASE_W   = 6;

    localparam logic [RATE_W-1:0] RATE_MIN = RATE_W'(500000);
    localparam logic [RATE_W-1:0] RATE_MAX = RATE_W'(XTAL_HZ / 2);

    // Decimation thresholds.
    localparam logic [RATE_W-1:0] RATE_X16 = RATE_W'(XTAL_HZ / 16);
    localparam logic [RATE_W-1:0] RATE_X32 = RATE_W'(XTAL_HZ / 32);
    localparam logic [RATE_W-1:0] RATE_X64 = RATE_W'(XTAL_HZ / 64);

    // Filter-select thresholds, crystal over a divisor given in tenths.
    localparam logic [RATE_W-1:0] RATE_T123 = RATE_W'((XTAL_HZ * 10) / 123);
    localparam logic [RATE_W-1:0] RATE_T146 = RATE_W'((XTAL_HZ * 10) / 146);
    localparam logic [RATE_W-1:0] RATE_T492 = RATE_W'((XTAL_HZ * 10) / 492);
    localparam logic [RATE_W-1:0] RATE_T984 = RATE_W'((XTAL_HZ * 10) / 984);

    // Baud ratio division: (s * 2^20 + FIN/2) / FIN, one quotient bit per step.
    localparam int RDIV_W     = 24;                 // divisor and trial width
    localparam int RREM_W     = RDIV_W - 1;         // remainder stays below FIN
    localparam int RQUO_W     = 24;                 // quotient bits computed
    localparam int RATIO_W    = 22;                 // bits kept
    localparam int RSHIFT     = 20;
    localparam int RNUM_W     = RATE_W + RSHIFT;
    localparam logic [RDIV_W-1:0] FIN      = RDIV_W'(XTAL_HZ / 16);
    localparam logic [RNUM_W-1:0] FIN_HALF = RNUM_W'((XTAL_HZ / 16) / 2);

    // Inverse ratio division: (XTAL * 32) / s. It runs the same number of steps
    // as the baud ratio divider, so its quotient is as wide.
    localparam int IQUO_W = 24;
    localparam int INUM_W = 32;
    localparam logic [INUM_W-1:0] INV_NUM = INUM_W'(XTAL_HZ * 32);
    localparam logic [RATE_W-1:0] INV_REM_INIT = RATE_W'((XTAL_HZ * 32) >> IQUO_W);
    localparam logic [IQUO_W-1:0] INV_SAT = IQUO_W'(255);

    // Division pipeline shape.
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = RQUO_W / BITS_PER_STAGE;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_DECIM_BASE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_BASE = CFG_IDX_W'(1);
    localparam logic [DBASE_W-1:0]   DECIM_BASE_RST  = DBASE_W'(10);
    localparam logic [BYTE_W-1:0]    FILTER_BASE_RST = BYTE_W'(99);

    // One word in flight through the division pipeline.
    typedef struct packed {
        logic [RATE_W-1:0] rate;
        logic [NDEC_W-1:0] ndec;
        logic              sfil;
        logic [RREM_W-1:0] rrem;
        logic [RQUO_W-1:0] rbits;
        logic [RQUO_W-1:0] rquo;
        logic [RATE_W-1:0] irem;
        logic [RATE_W-1:0] idiv;
        logic [IQUO_W-1:0] ibits;
        logic [IQUO_W-1:0] iquo;
    } srrc_item_t;

endpackage

>>> rtl/core/srrc_clamp.sv
// Input stage: clamp the requested rate into the supported range.
module srrc_clamp
    import srrc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [REQ_W-1:0]  in_rate,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [RATE_W-1:0] out_rate
);

    logic              valid_reg;
    logic [RATE_W-1:0] rate_reg;
    logic [RATE_W-1:0] rate_next;

    assign in_ready = ~valid_reg | out_ready;

    always_comb begin
        if (in_rate > REQ_W'(RATE_MAX)) begin
            rate_next = RATE_MAX;
        end else if (in_rate < REQ_W'(RATE_MIN)) begin
            rate_next = RATE_MIN;
        end else begin
            rate_next = in_rate[RATE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            rate_reg <= rate_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_rate  = rate_reg;

endmodule

>>> rtl/core/srrc_prep.sv
// Select stage: decimation count, filter bit and division seeds.
module srrc_prep
    import srrc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [RATE_W-1:0] in_rate,
    output logic              out_valid,
    input  logic              out_ready,
    output srrc_item_t        out_item
);

    logic              valid_reg;
    srrc_item_t        item_reg;
    srrc_item_t        item_next;
    logic [NDEC_W-1:0] ndec;
    logic              sfil;
    logic [RATE_W-1:0] scaled;
    logic [RNUM_W-1:0] num;

    assign in_ready = ~valid_reg | out_ready;

    always_comb begin
        priority if (in_rate < RATE_X64) begin
            ndec = NDEC_W'(3);
        end else if (in_rate < RATE_X32) begin
            ndec = NDEC_W'(2);
        end else if (in_rate < RATE_X16) begin
            ndec = NDEC_W'(1);
        end else begin
            ndec = NDEC_W'(0);
        end
    end

    // Later thresholds in the chain override earlier ones: test from the last.
    always_comb begin
        priority if (in_rate < RATE_T984) begin
            sfil = 1'b1;
        end else if (in_rate < RATE_X64) begin
            sfil = 1'b0;
        end else if (in_rate < RATE_T492) begin
            sfil = 1'b1;
        end else if (in_rate < RATE_X32) begin
            sfil = 1'b0;
        end else if (in_rate < RATE_T146) begin
            sfil = 1'b1;
        end else if (in_rate < RATE_X16) begin
            sfil = 1'b0;
        end else if (in_rate < RATE_T123) begin
            sfil = 1'b1;
        end else begin
            sfil = 1'b0;
        end
    end

    always_comb begin
        scaled = in_rate << ndec;
        num    = {scaled, RSHIFT'(0)} + FIN_HALF;

        item_next       = '0;
        item_next.rate  = in_rate;
        item_next.ndec  = ndec;
        item_next.sfil  = sfil;
        item_next.rrem  = RREM_W'(num[RNUM_W-1:RQUO_W]);
        item_next.rbits = num[RQUO_W-1:0];
        item_next.rquo  = '0;
        item_next.irem  = INV_REM_INIT;
        item_next.idiv  = scaled;
        item_next.ibits = INV_NUM[IQUO_W-1:0];
        item_next.iquo  = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

>>> rtl/core/srrc_div_stage.sv
// Division stage: advance both restoring dividers by a fixed number of quotient bits.
module srrc_div_stage
    import srrc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  srrc_item_t in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output srrc_item_t out_item
);

    logic        valid_reg;
    srrc_item_t  item_reg;
    srrc_item_t  item_next;

    logic [RDIV_W-1:0] rtrial;
    logic [RATE_W:0]   itrial;

    assign in_ready = ~valid_reg | out_ready;

    always_comb begin
        item_next = in_item;
        rtrial    = '0;
        itrial    = '0;
        for (int k = 0; k < BITS_PER_STAGE; k++) begin
            // Baud ratio: shift in the next dividend bit, subtract FIN when it fits.
            rtrial          = {item_next.rrem, item_next.rbits[RQUO_W-1]};
            item_next.rbits = item_next.rbits << 1;
            if (rtrial >= FIN) begin
                rtrial         = rtrial - FIN;
                item_next.rquo = {item_next.rquo[RQUO_W-2:0], 1'b1};
            end else begin
                item_next.rquo = {item_next.rquo[RQUO_W-2:0], 1'b0};
            end
            item_next.rrem = rtrial[RREM_W-1:0];

            // Inverse ratio: same step against the scaled rate.
            itrial          = {item_next.irem, item_next.ibits[IQUO_W-1]};
            item_next.ibits = item_next.ibits << 1;
            if (itrial >= {1'b0, item_next.idiv}) begin
                itrial         = itrial - {1'b0, item_next.idiv};
                item_next.iquo = {item_next.iquo[IQUO_W-2:0], 1'b1};
            end else begin
                item_next.iquo = {item_next.iquo[IQUO_W-2:0], 1'b0};
            end
            item_next.irem = itrial[RATE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

>>> rtl/core/symbol_rate_register_calculator.sv
// Top level of the symbol rate register calculator: clamp, select, divide, merge.
//
//  channel   | direction | handshake               | payload
//  ----------+-----------+-------------------------+------------------------------------
//  s_        | in        | s_tvalid / s_tready     | s_tdata[31:0]  rate_request
//  m_        | out       | m_tvalid / m_tready     | m_tdata[71:0]  five register values
//  cfg_      | in        | cfg_valid / cfg_ready   | cfg_index, cfg_data (base bytes)
//
// Each word passes from s_ to m_ through one clamp stage, one select stage and
// twelve division stages, each resolving two quotient bits of the baud ratio divider
// and two of the inverse ratio divider. A new word enters every cycle s_tready is high.
// Reset clears only the stage valid bits and the two base registers.
// Each stage holds its word while the next one is full and stalled; empty stages
// keep filling behind a stalled output, so s_tready drops only when every stage
// holds a word. The base bytes are merged at the output from the live registers.
module symbol_rate_register_calculator
    import srrc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,    // [31:0] rate_request

    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [25:0] clamped_rate, [33:26] decim_reg, [55:34] baud_ratio,
    // [63:56] inverse_ratio, [71:64] filter_reg
    output logic [71:0]          m_tdata,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data
);

    logic [DBASE_W-1:0] decim_base_reg;
    logic [BYTE_W-1:0]  filter_base_reg;

    logic              clamp_valid;
    logic              clamp_ready;
    logic [RATE_W-1:0] clamp_rate;

    logic       stage_valid [DIV_STAGES+1];
    logic       stage_ready [DIV_STAGES+1];
    srrc_item_t stage_item  [DIV_STAGES+1];

    srrc_item_t          last_item;
    logic [IQUO_W:0]     inv_sum;
    logic [IQUO_W-1:0]   inv_half;
    logic [BYTE_W-1:0]   inverse_ratio;
    logic [BYTE_W-1:0]   decim_reg;
    logic [BYTE_W-1:0]   filter_reg;

    // Configuration: always ready, unknown indexes drop the word.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decim_base_reg  <= DECIM_BASE_RST;
            filter_base_reg <= FILTER_BASE_RST;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_DECIM_BASE) begin
                decim_base_reg <= cfg_data[DBASE_W-1:0];
            end
            if (cfg_index == CFG_FILTER_BASE) begin
                filter_base_reg <= cfg_data;
            end
        end
    end

    srrc_clamp u_clamp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_rate   (s_tdata),
        .out_valid (clamp_valid),
        .out_ready (clamp_ready),
        .out_rate  (clamp_rate)
    );

    srrc_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (clamp_valid),
        .in_ready  (clamp_ready),
        .in_rate   (clamp_rate),
        .out_valid (stage_valid[0]),
        .out_ready (stage_ready[0]),
        .out_item  (stage_item[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        srrc_div_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stage_valid[g]),
            .in_ready  (stage_ready[g]),
            .in_item   (stage_item[g]),
            .out_valid (stage_valid[g+1]),
            .out_ready (stage_ready[g+1]),
            .out_item  (stage_item[g+1])
        );
    end

    // Last division stage is the output register.
    assign last_item               = stage_item[DIV_STAGES];
    assign m_tvalid                = stage_valid[DIV_STAGES];
    assign stage_ready[DIV_STAGES] = m_tready;

    // Round the inverse quotient to half and saturate at one byte.
    always_comb begin
        inv_sum  = {1'b0, last_item.iquo} + (IQUO_W+1)'(1);
        inv_half = inv_sum[IQUO_W:1];
        if (inv_half > INV_SAT) begin
            inverse_ratio = INV_SAT[BYTE_W-1:0];
        end else begin
            inverse_ratio = inv_half[BYTE_W-1:0];
        end
    end

    assign decim_reg  = {last_item.ndec, decim_base_reg};
    assign filter_reg = filter_base_reg | {3'b000, last_item.sfil, 4'b0000};

    assign m_tdata = {filter_reg,
                      inverse_ratio,
                      last_item.rquo[RATIO_W-1:0],
                      decim_reg,
                      last_item.rate};

endmodule

>>> tb/srrc_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the symbol rate calculator: tracks base registers, predicts and compares words.
module srrc_result_checker
    import srrc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [31:0]          s_tdata,    // [31:0] rate_request
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    // [25:0] clamped_rate, [33:26] decim_reg, [55:34] baud_ratio,
    // [63:56] inverse_ratio, [71:64] filter_reg
    input  logic [71:0]          m_tdata,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    output int                   fail_count,
    output int                   pending,
    output int                   checked
);

    // Field order matches the result word, lowest field last.
    typedef struct packed {
        logic [7:0]  filter_reg;
        logic [7:0]  inverse_ratio;
        logic [21:0] baud_ratio;
        logic [7:0]  decim_reg;
        logic [25:0] clamped_rate;
    } reg_set_t;

    typedef struct {
        logic [31:0] request;
        reg_set_t    regs;
    } rate_job_t;

    localparam longint unsigned XTAL        = XTAL_HZ;
    localparam longint unsigned FIN_HZ      = XTAL / 16;
    localparam longint unsigned RATE_FLOOR  = 500000;
    localparam longint unsigned RATE_TOP    = XTAL / 2;
    localparam longint unsigned DEC1_THR    = XTAL / 16;
    localparam longint unsigned DEC2_THR    = XTAL / 32;
    localparam longint unsigned DEC3_THR    = XTAL / 64;
    localparam longint unsigned FSEL_T123   = (XTAL * 10) / 123;
    localparam longint unsigned FSEL_T146   = (XTAL * 10) / 146;
    localparam longint unsigned FSEL_T492   = (XTAL * 10) / 492;
    localparam longint unsigned FSEL_T984   = (XTAL * 10) / 984;
    localparam longint unsigned INV_CAP     = 255;
    localparam logic [5:0]      DECIM_RESET = 6'd10;
    localparam logic [7:0]      FILTER_RESET = 8'd99;

    rate_job_t  expected_regs[$];
    logic [5:0] decim_base_q;
    logic [7:0] filter_base_q;

    initial begin
        fail_count = 0;
        pending    = 0;
        checked    = 0;
    end

    function automatic reg_set_t predict_registers(input logic [31:0] request,
                                                   input logic [5:0] dbase,
                                                   input logic [7:0] fbase);
        longint unsigned rate, ndec, sfil, s, q, rem, ratio, inv;
        reg_set_t r;
        rate = request;
        if (rate > RATE_TOP)
            rate = RATE_TOP;
        if (rate < RATE_FLOOR)
            rate = RATE_FLOOR;

        ndec = 0;
        if (rate < DEC1_THR) ndec = 1;
        if (rate < DEC2_THR) ndec = 2;
        if (rate < DEC3_THR) ndec = 3;

        // Later thresholds override earlier ones.
        sfil = 0;
        if (rate < FSEL_T123) sfil = 1;
        if (rate < DEC1_THR)  sfil = 0;
        if (rate < FSEL_T146) sfil = 1;
        if (rate < DEC2_THR)  sfil = 0;
        if (rate < FSEL_T492) sfil = 1;
        if (rate < DEC3_THR)  sfil = 0;
        if (rate < FSEL_T984) sfil = 1;

        s = rate << ndec;

        // Three-stage long division, rounding in the last stage.
        q     = (s << 4) / FIN_HZ;
        rem   = ((s << 4) % FIN_HZ) << 8;
        ratio = (q << 8) + rem / FIN_HZ;
        rem   = (rem % FIN_HZ) << 8;
        ratio = (ratio << 8) + (rem + FIN_HZ / 2) / FIN_HZ;

        inv = (((XTAL << 5) / s) + 1) / 2;
        if (inv > INV_CAP)
            inv = INV_CAP;

        r.clamped_rate  = 26'(rate);
        r.decim_reg     = 8'((ndec << 6) | dbase);
        r.baud_ratio    = 22'(ratio);
        r.inverse_ratio = 8'(inv);
        r.filter_reg    = 8'((sfil << 4) | fbase);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t ns] MISMATCH %s", $time, msg);
        fail_count = fail_count + 1;
    endtask

    always @(posedge aclk) begin : watch
        rate_job_t job;
        reg_set_t  got;
        if (!aresetn) begin
            decim_base_q  <= DECIM_RESET;
            filter_base_q <= FILTER_RESET;
            expected_regs.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                // Drop writes to indexes that hold no register.
                if (cfg_index == CFG_DECIM_BASE)
                    decim_base_q <= cfg_data[5:0];
                else if (cfg_index == CFG_FILTER_BASE)
                    filter_base_q <= cfg_data;
            end
            if (s_tvalid && s_tready) begin
                job.request = s_tdata;
                job.regs    = predict_registers(s_tdata, decim_base_q, filter_base_q);
                expected_regs.push_back(job);
            end
            if (m_tvalid && m_tready) begin
                got = reg_set_t'(m_tdata);
                if (expected_regs.size() == 0) begin
                    report_mismatch($sformatf("unexpected result word 0x%h", m_tdata));
                end else begin
                    job = expected_regs.pop_front();
                    checked = checked + 1;
                    if (got.clamped_rate !== job.regs.clamped_rate)
                        report_mismatch($sformatf("req %0d clamped_rate: exp %0d got %0d",
                            job.request, job.regs.clamped_rate, got.clamped_rate));
                    if (got.decim_reg !== job.regs.decim_reg)
                        report_mismatch($sformatf("req %0d decim_reg: exp 0x%h got 0x%h",
                            job.request, job.regs.decim_reg, got.decim_reg));
                    if (got.baud_ratio !== job.regs.baud_ratio)
                        report_mismatch($sformatf("req %0d baud_ratio: exp 0x%h got 0x%h",
                            job.request, job.regs.baud_ratio, got.baud_ratio));
                    if (got.inverse_ratio !== job.regs.inverse_ratio)
                        report_mismatch($sformatf("req %0d inverse_ratio: exp %0d got %0d",
                            job.request, job.regs.inverse_ratio, got.inverse_ratio));
                    if (got.filter_reg !== job.regs.filter_reg)
                        report_mismatch($sformatf("req %0d filter_reg: exp 0x%h got 0x%h",
                            job.request, job.regs.filter_reg, got.filter_reg));
                end
            end
        end
        pending = expected_regs.size();
    end

endmodule

>>> tb/symbol_rate_register_calculator_tb.sv
`timescale 1ns / 1ps
// Testbench top for the symbol rate calculator: stimulus, pacing, watchdog and verdict.
module symbol_rate_register_calculator_tb;
    import srrc_pkg::*;

    localparam int RESET_CYCLES     = 9;
    localparam int DRAIN_CYCLES     = 24;    // pipeline is 14 deep, leave margin
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int CHUNK_ITEMS      = 130;
    localparam int SETTINGS_PER_MODE = 4;
    localparam int BOUNDARY_COUNT   = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LAST  = CFG_IDX_W'(255);

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata   = '0;    // [31:0] rate_request
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    // [25:0] clamped_rate, [33:26] decim_reg, [55:34] baud_ratio,
    // [63:56] inverse_ratio, [71:64] filter_reg
    logic [71:0]          m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [BYTE_W-1:0]    cfg_data  = '0;

    int fail_count;
    int pending;
    int checked;
    int tx_idle_pct = 15;
    int rx_idle_pct = 47;
    int idle_cycles = 0;
    int items_sent = 0;
    int settings_applied = 0;

    always #6 aclk = ~aclk;

    symbol_rate_register_calculator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    srrc_result_checker result_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    // Stall the result side at random; one draw per cycle.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Abort when no word moves on any channel for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no word accepted for %0d cycles", WATCHDOG_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Rates where clamping, decimation or filter select change.
    function automatic longint unsigned boundary_rate(input int k);
        case (k)
            0:       return RATE_MIN;
            1:       return RATE_MAX;
            2:       return RATE_X16;
            3:       return RATE_X32;
            4:       return RATE_X64;
            5:       return RATE_T123;
            6:       return RATE_T146;
            7:       return RATE_T492;
            default: return RATE_T984;
        endcase
    endfunction

    // Offer one rate word after a random gap; return at the falling edge after acceptance.
    task automatic send_rate(input logic [31:0] rate);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rate;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        @(negedge aclk);
    endtask

    // Hold one register write until accepted; the caller lowers cfg_valid.
    task automatic write_word(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    // Wait until every expected word has come back, then let the pipeline settle.
    task automatic wait_drained();
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    initial begin
        int          mode;
        int          set;
        int          n;
        int          k;
        int          sel;
        logic [7:0]  dval;
        logic [7:0]  fval;
        logic [31:0] req;

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: both sides of every clamp, decimation and filter threshold,
        // plus the field extremes, all under the reset base values.
        for (k = 0; k < BOUNDARY_COUNT; k++) begin
            send_rate(32'(boundary_rate(k)) - 32'd1);
            send_rate(32'(boundary_rate(k)));
        end
        send_rate(32'(RATE_MAX) + 32'd1);
        send_rate(32'd0);
        send_rate(32'hFFFF_FFFF);
        s_tvalid <= 1'b0;
        wait_drained();

        for (mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    tx_idle_pct = 15;
                    rx_idle_pct = 47;
                end
                1: begin
                    tx_idle_pct = 47;
                    rx_idle_pct = 15;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase

            for (set = 0; set < SETTINGS_PER_MODE; set++) begin
                // Cover all-zero, all-one (upper decim bits masked), filter bit four
                // already set, and a random pair.
                case (set)
                    0: begin
                        dval = 8'h00;
                        fval = 8'h00;
                    end
                    1: begin
                        dval = 8'hFF;
                        fval = 8'hFF;
                    end
                    2: begin
                        dval = 8'hD5;
                        fval = 8'h10;
                    end
                    default: begin
                        dval = 8'($urandom_range(0, 255));
                        fval = 8'($urandom_range(0, 255));
                    end
                endcase
                write_word(CFG_DECIM_BASE, dval);
                write_word(CFG_FILTER_BASE, fval);
                if (set == 2) begin
                    // Writes to unused indexes must leave both bases alone.
                    write_word(CFG_IDX_SPARE, ~fval);
                    write_word(CFG_IDX_LAST, ~dval);
                end
                cfg_valid <= 1'b0;
                settings_applied++;

                for (n = 0; n < CHUNK_ITEMS; n++) begin
                    sel = $urandom_range(0, 99);
                    if (sel < 12)
                        req = $urandom;
                    else if (sel < 20)
                        req = $urandom_range(0, 32'(RATE_MIN) - 1);
                    else if (sel < 45)
                        req = 32'(boundary_rate($urandom_range(0, BOUNDARY_COUNT - 1)))
                              - 32'd4 + 32'($urandom_range(0, 8));
                    else
                        req = $urandom_range(32'(RATE_MIN), 32'(RATE_MAX));
                    send_rate(req);
                end
                s_tvalid <= 1'b0;
                wait_drained();
            end
        end

        $display("Checked %0d result words for %0d rate requests over %0d base settings",
                 checked, items_sent, settings_applied);
        $display("Pacing 15/47, 47/15 and 0/0 percent idle; all thresholds hit from both sides");
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/srrc_pkg.sv
rtl/core/srrc_clamp.sv
rtl/core/srrc_prep.sv
rtl/core/srrc_div_stage.sv
rtl/core/symbol_rate_register_calculator.sv
tb/srrc_result_checker.sv
tb/symbol_rate_register_calculator_tb.sv
